// ----- src/slru_pkg.sv -----
// Package for the size-bounded LRU cache: controller state type and
// the status/command structs shared by the controller and datapath.
package slru_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_EVICT,
    ST_FULLCHK,
    ST_INSERT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;      // capture request
    logic touch;     // hit: promote found entry
    logic evict;     // drop least recent entry
    logic insert;    // write request into free slot
    logic count_ev;  // bump eviction count
    logic set_hit;
    logic set_stored;
  } cmd_t;

  typedef struct packed {
    logic found;
    logic over;      // total + size > budget
    logic nonzero;   // total != 0
    logic fits;
    logic full;
    logic any_valid;
  } stat_t;

endpackage

// ----- src/slru_if.sv -----
// Valid/ready channel interface carrying a parameterized payload.
// Depends on nothing.
interface slru_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- src/size_bounded_lru_cache.sv -----
// Size-bounded LRU cache with a byte budget. Each request takes one
// item through a controller walking a slot table: a hit goes from
// lookup straight to the result; a miss evicts one entry per cycle
// while over budget, then inserts the item if it fits.
// One result per request; the result holds until taken.
module size_bounded_lru_cache #(
  parameter int ENTRIES   = 16,
  parameter int KEY_BITS  = 32,
  parameter int SIZE_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_data_i,
  slru_if.sink        req,
  slru_if.source      rsp
);
  import slru_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  slru_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req.valid),
    .in_ready_o  (req.ready),
    .out_valid_o (rsp.valid),
    .out_ready_i (rsp.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  slru_dp #(
    .ENTRIES   (ENTRIES),
    .KEY_BITS  (KEY_BITS),
    .SIZE_BITS (SIZE_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .key_i      (req.data.object_key),
    .size_i     (req.data.object_size),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .hit_o      (rsp.data.hit),
    .stored_o   (rsp.data.stored),
    .evicted_o  (rsp.data.evicted_count),
    .bytes_o    (rsp.data.bytes_in_use)
  );
endmodule

// ----- src/slru_ctrl.sv -----
// Controller state machine for the LRU cache.
// Depends on slru_pkg.
module slru_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  slru_pkg::stat_t stat_i,
  output slru_pkg::cmd_t  cmd_o
);
  import slru_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (in_valid_i) state_d = ST_LOOKUP;
      ST_LOOKUP:  state_d = stat_i.found ? ST_DONE : ST_EVICT;
      ST_EVICT: begin
        if (!(stat_i.over && stat_i.nonzero && stat_i.any_valid)) begin
          state_d = stat_i.fits ? ST_FULLCHK : ST_DONE;
        end
      end
      ST_FULLCHK: state_d = ST_INSERT;
      ST_INSERT:  state_d = ST_DONE;
      ST_DONE:    if (out_ready_i) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_LOOKUP: begin
        cmd_o.touch   = stat_i.found;
        cmd_o.set_hit = stat_i.found;
      end
      ST_EVICT: begin
        if (stat_i.over && stat_i.nonzero && stat_i.any_valid) begin
          cmd_o.evict    = 1'b1;
          cmd_o.count_ev = 1'b1;
        end
      end
      ST_FULLCHK: begin
        cmd_o.evict    = stat_i.full;
        cmd_o.count_ev = stat_i.full;
      end
      ST_INSERT: begin
        cmd_o.insert     = 1'b1;
        cmd_o.set_stored = 1'b1;
      end
      ST_DONE:    out_valid_o = 1'b1;
      default: ;
    endcase
  end
endmodule

// ----- src/slru_dp.sv -----
// Datapath for the LRU cache: slot table, recency ranks, byte total,
// request and result registers. Depends on slru_pkg.
module slru_dp #(
  parameter int ENTRIES   = 16,
  parameter int KEY_BITS  = 32,
  parameter int SIZE_BITS = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [31:0]          key_i,
  input  logic [23:0]          size_i,
  input  logic                 cfg_we_i,
  input  logic [31:0]          cfg_data_i,
  input  slru_pkg::cmd_t       cmd_i,
  output slru_pkg::stat_t      stat_o,
  output logic                 hit_o,
  output logic                 stored_o,
  output logic [4:0]           evicted_o,
  output logic [31:0]          bytes_o
);
  import slru_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int SW = (SIZE_BITS < 24) ? SIZE_BITS : 24;

  logic [KEY_BITS-1:0] slot_key_q   [ENTRIES];
  logic [SW-1:0]       slot_bytes_q [ENTRIES];
  logic [ENTRIES-1:0]  valid_q;
  logic [IW-1:0]       rank_q       [ENTRIES];
  logic [31:0]         total_q;
  logic [31:0]         budget_q;
  logic [KEY_BITS-1:0] key_q;
  logic [SW-1:0]       size_q;
  logic                hit_q, stored_q;
  logic [4:0]          ev_q;

  logic [ENTRIES-1:0]  match, oldest;
  logic [IW-1:0]       found_idx, old_idx, free_idx;
  logic [IW-1:0]       found_rank;
  logic [CW-1:0]       nvalid;
  logic [32:0]         sum;
  logic [KEY_BITS-1:0] key_in;

  if (KEY_BITS <= 32) begin : g_knarrow
    assign key_in = key_i[KEY_BITS-1:0];
  end else begin : g_kwide
    assign key_in = {{(KEY_BITS-32){1'b0}}, key_i};
  end

  always_comb begin
    found_idx = '0;
    old_idx   = '0;
    free_idx  = '0;
    nvalid    = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]  = valid_q[i] && (slot_key_q[i] == key_q);
      oldest[i] = valid_q[i] && (rank_q[i] == '0);
      if (match[i])  found_idx = IW'(i);
      if (oldest[i]) old_idx   = IW'(i);
      nvalid = nvalid + CW'(valid_q[i]);
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_q[i]) free_idx = IW'(i);
    end
  end

  assign found_rank = rank_q[found_idx];
  assign sum = {1'b0, total_q} + 33'(size_q);

  assign stat_o.found     = |match;
  assign stat_o.over      = sum > {1'b0, budget_q};
  assign stat_o.nonzero   = total_q != '0;
  assign stat_o.fits      = !stat_o.over;
  assign stat_o.full      = &valid_q;
  assign stat_o.any_valid = |oldest;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q  <= key_in;
      size_q <= size_i[SW-1:0];
    end
    if (cmd_i.insert) begin
      slot_key_q[free_idx]   <= key_q;
      slot_bytes_q[free_idx] <= size_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      total_q  <= '0;
      budget_q <= 32'd1048576;
      hit_q    <= 1'b0;
      stored_q <= 1'b0;
      ev_q     <= '0;
      for (int i = 0; i < ENTRIES; i++) rank_q[i] <= '0;
    end else begin
      if (cfg_we_i) budget_q <= cfg_data_i;
      if (cmd_i.load) begin
        hit_q    <= 1'b0;
        stored_q <= 1'b0;
        ev_q     <= '0;
      end
      if (cmd_i.set_hit)    hit_q    <= 1'b1;
      if (cmd_i.set_stored) stored_q <= 1'b1;
      if (cmd_i.count_ev && ev_q != 5'd31) ev_q <= ev_q + 5'd1;
      if (cmd_i.touch) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid_q[i] && rank_q[i] > found_rank) rank_q[i] <= rank_q[i] - 1'b1;
        end
        rank_q[found_idx] <= IW'(nvalid - CW'(1));
      end
      if (cmd_i.evict) begin
        valid_q[old_idx] <= 1'b0;
        total_q <= total_q - 32'(slot_bytes_q[old_idx]);
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid_q[i] && rank_q[i] != '0) rank_q[i] <= rank_q[i] - 1'b1;
        end
      end
      if (cmd_i.insert) begin
        valid_q[free_idx] <= 1'b1;
        rank_q[free_idx]  <= IW'(nvalid);
        total_q <= total_q + 32'(size_q);
      end
    end
  end

  assign hit_o     = hit_q;
  assign stored_o  = stored_q;
  assign evicted_o = ev_q;
  assign bytes_o   = total_q;
endmodule
